// ===== sv/srn_pkg.sv =====
// types, codes and constants shared by the sensor reading normalizer
package srn_pkg;

	localparam int VALUE_WIDTH_DEF = 64;

	localparam logic [3:0] KIND_TEMP = 4'd2;
	localparam logic [3:0] KIND_VOLT = 4'd3;
	localparam logic [3:0] KIND_CURR = 4'd4;
	localparam logic [3:0] KIND_FAN  = 4'd12;

	localparam logic [6:0] UNIT_C   = 7'd2;
	localparam logic [6:0] UNIT_F   = 7'd3;
	localparam logic [6:0] UNIT_K   = 7'd4;
	localparam logic [6:0] UNIT_V   = 7'd5;
	localparam logic [6:0] UNIT_A   = 7'd6;
	localparam logic [6:0] UNIT_RPM = 7'd19;

	localparam logic [31:0] HEALTH_OK            = 32'd2;
	localparam logic [31:0] HEALTH_DEGRADED      = 32'd3;
	localparam logic [31:0] HEALTH_STRESSED      = 32'd4;
	localparam logic [31:0] HEALTH_PRED_FAIL     = 32'd5;
	localparam logic [31:0] HEALTH_ERROR         = 32'd6;
	localparam logic [31:0] HEALTH_NONRECOVER    = 32'd7;
	localparam logic [31:0] HEALTH_STARTING      = 32'd8;
	localparam logic [31:0] HEALTH_STOPPING      = 32'd9;
	localparam logic [31:0] HEALTH_IN_SERVICE    = 32'd11;
	localparam logic [31:0] HEALTH_NO_CONTACT    = 32'd12;
	localparam logic [31:0] HEALTH_LOST_COMM     = 32'd13;
	localparam logic [31:0] HEALTH_ABORTED       = 32'd14;
	localparam logic [31:0] HEALTH_SUPPORT_ERR   = 32'd16;
	localparam logic [31:0] HEALTH_COMPLETED     = 32'd17;
	localparam logic [31:0] HEALTH_DONE_DEGRADED = 32'd20;
	localparam logic [31:0] HEALTH_DONE_ERROR    = 32'd23;

	localparam logic [2:0] CLASS_NONE = 3'd0;
	localparam logic [2:0] CLASS_TEMP = 3'd1;
	localparam logic [2:0] CLASS_VOLT = 3'd2;
	localparam logic [2:0] CLASS_CURR = 3'd3;
	localparam logic [2:0] CLASS_FAN  = 3'd4;

	localparam int F_OFFSET = 32000;
	localparam int K_OFFSET = 273150;

	localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCC;
	localparam logic [31:0] DIV9_RECIP  = 32'hE38E38E3;
	localparam logic [31:0] DIV9_SPAN   = 32'h1C71C71C;

	typedef struct packed {
		logic [31:0]       raw_reading;
		logic signed [7:0] decimal_exponent;
		logic [3:0]        kind_code;
		logic [6:0]        unit_code;
		logic [31:0]       health_code;
	} srn_in_t;

	typedef struct packed {
		logic signed [63:0] scaled_value;
		logic [2:0]         class_code;
		logic               is_connected;
		logic               has_fault;
	} srn_out_t;

	typedef struct packed {
		logic zero;
		logic big;
		logic le_fifth;
	} srn_flags_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV10,
		OP_MUL10,
		OP_SAT,
		OP_SUB_F,
		OP_SUB_K,
		OP_MUL5,
		OP_ABS,
		OP_DIV9,
		OP_ROUND9
	} srn_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DOWN,
		S_UP,
		S_CONV,
		S_FSEL,
		S_ABS,
		S_DIV9,
		S_ROUND,
		S_MUL5,
		S_DONE
	} srn_state_t;

endpackage

// ===== sv/srn_datapath.sv =====
// shared arithmetic unit: accumulator with divide, multiply, offset and 32-bit chunk divide steps
module srn_datapath #(
	parameter int VALUE_WIDTH = srn_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  srn_pkg::srn_op_t   op,
	input  logic [31:0]        raw_reading,
	output srn_pkg::srn_flags_t flags,
	output logic [VALUE_WIDTH-1:0] acc
);
	import srn_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int NC = (VW + 31) / 32;
	localparam int DW = 32 * NC;
	localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] VMAX_DIV10 = VMAX / 10;
	localparam logic [VW-1:0] VMAX_DIV5 = VMAX / 5;

	logic [VW-1:0] acc_q;
	logic [DW-1:0] dq_q;
	logic [3:0]    rem_q;
	logic          neg_q;

	logic [32:0] d10_x;
	logic [64:0] d10_p;
	logic [29:0] d10_q0;
	logic [33:0] d10_r;
	logic [29:0] d10_q;

	logic [32:0] d9_y;
	logic [64:0] d9_p;
	logic [29:0] d9_q0;
	logic [33:0] d9_r;
	logic        d9_fix;
	logic [29:0] d9_q;
	logic [3:0]  d9_rem;
	logic [31:0] d9_hi;
	logic [31:0] d9_chunk;

	logic [VW-1:0] mag;
	logic [VW-1:0] qm;

	always_comb begin
		d10_x = acc_q[32:0] + 33'd5;
		d10_p = {32'd0, d10_x} * {33'd0, DIV10_RECIP};
		d10_q0 = d10_p[64:35];
		d10_r = {1'b0, d10_x} - (34'({d10_q0, 3'b000}) + 34'({d10_q0, 1'b0}));
		d10_q = d10_q0 + 30'(d10_r >= 34'd10);
	end

	// remainder times 2^32 splits into remainder times the span plus four times remainder
	always_comb begin
		d9_y = {1'b0, dq_q[DW-1 -: 32]} + {27'd0, rem_q, 2'b00};
		d9_p = {32'd0, d9_y} * {33'd0, DIV9_RECIP};
		d9_q0 = d9_p[64:35];
		d9_r = {1'b0, d9_y} - (34'({d9_q0, 3'b000}) + 34'(d9_q0));
		d9_fix = (d9_r >= 34'd9);
		d9_q = d9_q0 + 30'(d9_fix);
		d9_rem = d9_fix ? 4'(d9_r - 34'd9) : d9_r[3:0];
		d9_hi = {28'd0, rem_q} * DIV9_SPAN;
		d9_chunk = d9_hi + {2'd0, d9_q};
	end

	always_comb begin
		mag = acc_q[VW-1] ? (~acc_q + VW'(1)) : acc_q;
		qm = dq_q[VW-1:0] + VW'(rem_q >= 4'd5);
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD:   acc_q <= VW'(raw_reading);
			OP_DIV10:  acc_q <= VW'(d10_q);
			OP_MUL10:  acc_q <= (acc_q << 3) + (acc_q << 1);
			OP_SAT:    acc_q <= VMAX;
			OP_SUB_F:  acc_q <= acc_q - VW'(F_OFFSET);
			OP_SUB_K:  acc_q <= acc_q - VW'(K_OFFSET);
			OP_MUL5:   acc_q <= (acc_q << 2) + acc_q;
			OP_ABS: begin
				neg_q <= acc_q[VW-1];
				dq_q <= DW'(mag);
				rem_q <= 4'd0;
			end
			OP_DIV9: begin
				dq_q <= {dq_q[DW-33:0], d9_chunk};
				rem_q <= d9_rem;
			end
			OP_ROUND9: acc_q <= neg_q ? (~qm + VW'(1)) : qm;
			default: ;
		endcase
	end

	always_comb begin
		flags.zero = (acc_q == '0);
		flags.big = (acc_q > VMAX_DIV10);
		flags.le_fifth = ($signed(acc_q) <= $signed(VMAX_DIV5));
		acc = acc_q;
	end

endmodule

// ===== sv/srn_status.sv =====
// class, connected and fault decode of one record, held for the result
module srn_status (
	input  logic             clk,
	input  logic             load,
	input  srn_pkg::srn_in_t item,
	output logic [2:0]       class_code,
	output logic             is_connected,
	output logic             has_fault
);
	import srn_pkg::*;

	logic [2:0] class_d;
	logic       fault_d;
	logic [2:0] class_q;
	logic       conn_q;
	logic       fault_q;

	always_comb begin
		class_d = CLASS_NONE;
		if (item.kind_code == KIND_TEMP && item.unit_code inside {UNIT_C, UNIT_F, UNIT_K}) begin
			class_d = CLASS_TEMP;
		end else if (item.kind_code == KIND_VOLT && item.unit_code == UNIT_V) begin
			class_d = CLASS_VOLT;
		end else if (item.kind_code == KIND_CURR && item.unit_code == UNIT_A) begin
			class_d = CLASS_CURR;
		end else if (item.kind_code == KIND_FAN && item.unit_code == UNIT_RPM) begin
			class_d = CLASS_FAN;
		end
		fault_d = item.health_code inside {HEALTH_DEGRADED, HEALTH_STRESSED,
			HEALTH_PRED_FAIL, HEALTH_ERROR, HEALTH_NONRECOVER, HEALTH_NO_CONTACT,
			HEALTH_LOST_COMM, HEALTH_ABORTED, HEALTH_SUPPORT_ERR,
			HEALTH_DONE_DEGRADED, HEALTH_DONE_ERROR};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			class_q <= class_d;
			conn_q <= (item.health_code != HEALTH_NO_CONTACT);
			fault_q <= fault_d;
		end
	end

	assign class_code = class_q;
	assign is_connected = conn_q;
	assign has_fault = fault_q;

endmodule

// ===== sv/srn_ctrl.sv =====
// sequencer: step counts, state machine and operation select for the shared unit
module srn_ctrl #(
	parameter int VALUE_WIDTH = srn_pkg::VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  srn_pkg::srn_in_t    item,
	input  srn_pkg::srn_flags_t flags,
	output srn_pkg::srn_op_t    op,
	output logic                busy,
	output logic                done
);
	import srn_pkg::*;

	localparam int NC = (VALUE_WIDTH + 31) / 32;
	localparam int DGW = $clog2(NC);

	srn_state_t     state_q;
	srn_state_t     state_d;
	logic [7:0]     cnt_q;
	logic [DGW-1:0] dig_q;
	logic           post_q;
	logic           temp_f_q;
	logic           temp_k_q;

	logic       is_fan;
	logic [8:0] diff;
	logic [7:0] steps;
	logic       cnt_end;

	always_comb begin
		is_fan = (item.kind_code == KIND_FAN);
		diff = {item.decimal_exponent[7], item.decimal_exponent} + (is_fan ? 9'd0 : 9'd3);
		steps = diff[8] ? 8'(~diff + 9'd1) : diff[7:0];
		cnt_end = (cnt_q == 8'd0) || flags.zero;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (diff[8]) state_d = S_DOWN;
					else if (diff == 9'd0) state_d = S_CONV;
					else state_d = S_UP;
				end
			end
			S_DOWN:  if (cnt_end) state_d = S_CONV;
			S_UP:    if (cnt_end || flags.big) state_d = S_CONV;
			S_CONV:  state_d = temp_f_q ? S_FSEL : S_DONE;
			S_FSEL:  state_d = S_ABS;
			S_ABS:   state_d = S_DIV9;
			S_DIV9:  if (dig_q == '0) state_d = S_ROUND;
			S_ROUND: state_d = post_q ? S_MUL5 : S_DONE;
			S_MUL5:  state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		done = 1'b0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:  if (start) op = OP_LOAD;
			S_DOWN:  if (!cnt_end) op = OP_DIV10;
			S_UP:    if (!cnt_end) op = flags.big ? OP_SAT : OP_MUL10;
			S_CONV: begin
				if (temp_f_q) op = OP_SUB_F;
				else if (temp_k_q) op = OP_SUB_K;
			end
			S_FSEL:  if (flags.le_fifth) op = OP_MUL5;
			S_ABS:   op = OP_ABS;
			S_DIV9:  op = OP_DIV9;
			S_ROUND: op = OP_ROUND9;
			S_MUL5:  op = OP_MUL5;
			S_DONE:  done = 1'b1;
			default: op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= 8'd0;
			dig_q <= '0;
			post_q <= 1'b0;
			temp_f_q <= 1'b0;
			temp_k_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_LOAD) begin
				cnt_q <= steps;
				temp_f_q <= (item.kind_code == KIND_TEMP) && (item.unit_code == UNIT_F);
				temp_k_q <= (item.kind_code == KIND_TEMP) && (item.unit_code == UNIT_K);
			end else if (op == OP_DIV10 || op == OP_MUL10) begin
				cnt_q <= cnt_q - 8'd1;
			end
			if (state_q == S_FSEL) post_q <= !flags.le_fifth;
			if (op == OP_ABS) dig_q <= DGW'(NC - 1);
			else if (op == OP_DIV9) dig_q <= dig_q - 1'b1;
		end
	end

endmodule

// ===== sv/sensor_reading_normalizer_unit.sv =====
// top level of the sensor reading normalizer
//
//  channel   ports                 handshake
//  record    item                  start high while busy low
//  result    result                done high for one cycle
//
// busy per record: decade loop, offset step and done, plus the Fahrenheit steps below
// decade loop: one divide or multiply by ten per step, skipped with no steps; it ends early
// once the value is zero or saturates
// Fahrenheit: select, magnitude, divide by nine in 32-bit chunks, round, times five
// reset clears the sequencer only; result is valid only with done
// results cannot be held off; busy stays high until the cycle after done
module sensor_reading_normalizer_unit #(
	parameter int VALUE_WIDTH = srn_pkg::VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  srn_pkg::srn_in_t  item,
	output logic              done,
	output srn_pkg::srn_out_t result
);
	import srn_pkg::*;

	srn_op_t              op;
	srn_flags_t           flags;
	logic [VALUE_WIDTH-1:0] acc;
	logic [2:0]           class_code;
	logic                 is_connected;
	logic                 has_fault;

	srn_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.flags(flags),
		.op(op),
		.busy(busy),
		.done(done)
	);

	srn_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk),
		.op(op),
		.raw_reading(item.raw_reading),
		.flags(flags),
		.acc(acc)
	);

	srn_status u_status (
		.clk(clk),
		.load(op == OP_LOAD),
		.item(item),
		.class_code(class_code),
		.is_connected(is_connected),
		.has_fault(has_fault)
	);

	always_comb begin
		result.scaled_value = 64'($signed(acc));
		result.class_code = class_code;
		result.is_connected = is_connected;
		result.has_fault = has_fault;
	end

endmodule

// ===== sv/srn_checker.sv =====
// port-level checks of the normalizer and their bind to the top level
module srn_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input srn_pkg::srn_out_t result
);
	import srn_pkg::*;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted record did not raise busy");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat outside busy");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after result beat");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.class_code <= CLASS_FAN)) else $error("class code out of range");

endmodule

bind sensor_reading_normalizer_unit srn_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);

// ===== test/tb_sensor_reading_normalizer_unit.sv =====
// self-checking testbench for the sensor reading normalizer unit
module tb_sensor_reading_normalizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import srn_pkg::*;

	localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
	localparam longint VALUE_MAX = longint'(64'h7FFF_FFFF_FFFF_FFFF >> (64 - VALUE_WIDTH));
	localparam int RANDOM_RECORDS = 1100;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 64;
	localparam int MAX_REPORTS = 40;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	srn_in_t  item = '0;
	logic     done;
	srn_out_t result;

	srn_in_t  record_q[$];
	srn_out_t normalized_q[$];
	bit       item_taken = 1'b0;
	int       gap_left = 0;
	int       taken_count = 0;
	int       stall_cycles = 0;
	int       errors = 0;

	sensor_reading_normalizer_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint round_div(longint x, longint d);
		longint unsigned mag;
		longint unsigned q;
		longint unsigned ud;
		ud = longint'(d);
		mag = (x >= 0) ? longint'(x) : longint'(-x);
		q = mag / ud;
		if ((mag % ud) * 2 >= ud) begin
			q = q + 1;
		end
		return (x >= 0) ? longint'(q) : -longint'(q);
	endfunction

	function automatic srn_out_t normalize_record(srn_in_t rec);
		srn_out_t r;
		longint v;
		int ex;
		int goal;
		v = longint'({32'd0, rec.raw_reading});
		ex = int'($signed(rec.decimal_exponent));
		goal = (rec.kind_code == KIND_FAN) ? 0 : -3;
		while (ex < goal) begin
			v = round_div(v, 10);
			ex++;
		end
		while (ex > goal) begin
			if (v > VALUE_MAX / 10) begin
				v = VALUE_MAX;
				ex = goal;
			end else begin
				v = v * 10;
				ex--;
			end
		end
		if (rec.kind_code == KIND_TEMP) begin
			if (rec.unit_code == UNIT_F) begin
				v = v - F_OFFSET;
				if (v <= VALUE_MAX / 5) begin
					v = round_div(v * 5, 9);
				end else begin
					v = round_div(v, 9) * 5;
				end
			end else if (rec.unit_code == UNIT_K) begin
				v = v - K_OFFSET;
			end
		end
		r.scaled_value = v;
		if (rec.kind_code == KIND_TEMP && (rec.unit_code == UNIT_C ||
				rec.unit_code == UNIT_F || rec.unit_code == UNIT_K)) begin
			r.class_code = CLASS_TEMP;
		end else if (rec.kind_code == KIND_VOLT && rec.unit_code == UNIT_V) begin
			r.class_code = CLASS_VOLT;
		end else if (rec.kind_code == KIND_CURR && rec.unit_code == UNIT_A) begin
			r.class_code = CLASS_CURR;
		end else if (rec.kind_code == KIND_FAN && rec.unit_code == UNIT_RPM) begin
			r.class_code = CLASS_FAN;
		end else begin
			r.class_code = CLASS_NONE;
		end
		r.is_connected = (rec.health_code != HEALTH_NO_CONTACT);
		case (rec.health_code)
			HEALTH_DEGRADED, HEALTH_STRESSED, HEALTH_PRED_FAIL, HEALTH_ERROR,
			HEALTH_NONRECOVER, HEALTH_NO_CONTACT, HEALTH_LOST_COMM, HEALTH_ABORTED,
			HEALTH_SUPPORT_ERR, HEALTH_DONE_DEGRADED, HEALTH_DONE_ERROR: r.has_fault = 1'b1;
			default: r.has_fault = 1'b0;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 30);
		end
		return $urandom_range(31, 90);
	endfunction

	function automatic srn_in_t random_record();
		srn_in_t rec;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			case ($urandom_range(0, 5))
				0: begin rec.kind_code = KIND_TEMP; rec.unit_code = UNIT_C; end
				1: begin rec.kind_code = KIND_TEMP; rec.unit_code = UNIT_F; end
				2: begin rec.kind_code = KIND_TEMP; rec.unit_code = UNIT_K; end
				3: begin rec.kind_code = KIND_VOLT; rec.unit_code = UNIT_V; end
				4: begin rec.kind_code = KIND_CURR; rec.unit_code = UNIT_A; end
				default: begin rec.kind_code = KIND_FAN; rec.unit_code = UNIT_RPM; end
			endcase
		end else if (r < 85) begin
			case ($urandom_range(0, 3))
				0: rec.kind_code = KIND_TEMP;
				1: rec.kind_code = KIND_VOLT;
				2: rec.kind_code = KIND_CURR;
				default: rec.kind_code = KIND_FAN;
			endcase
			rec.unit_code = 7'($urandom_range(0, 127));
		end else begin
			rec.kind_code = 4'($urandom_range(0, 15));
			rec.unit_code = 7'($urandom_range(0, 127));
		end
		r = $urandom_range(0, 99);
		if (r < 75) begin
			rec.decimal_exponent = 8'($signed($urandom_range(0, 24)) - 12);
		end else if (r < 90) begin
			rec.decimal_exponent = 8'($signed($urandom_range(0, 40)) - 20);
		end else begin
			rec.decimal_exponent = 8'($urandom_range(0, 255));
		end
		r = $urandom_range(0, 99);
		if (r < 40) begin
			rec.raw_reading = $urandom_range(0, 100000);
		end else if (r < 80) begin
			rec.raw_reading = $urandom;
		end else if (r < 90) begin
			rec.raw_reading = 32'hFFFF_FFFF - $urandom_range(0, 1000);
		end else begin
			rec.raw_reading = $urandom_range(0, 9);
		end
		rec.health_code = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 31) : $urandom;
		return rec;
	endfunction

	task automatic add_record(logic [31:0] raw, logic signed [7:0] expo, logic [3:0] kind,
			logic [6:0] unit, logic [31:0] health);
		srn_in_t rec;
		rec.raw_reading = raw;
		rec.decimal_exponent = expo;
		rec.kind_code = kind;
		rec.unit_code = unit;
		rec.health_code = health;
		record_q.push_back(rec);
	endtask

	// record beats change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && !item_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (record_q.size() > 0) begin
				item <= record_q.pop_front();
				start <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		srn_out_t want;
		item_taken = arst_n && start && !busy;
		if (arst_n && done) begin
			if (normalized_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t unexpected result: expected none,", $time,
						" actual value=%0d class=%0d conn=%0b fault=%0b",
						result.scaled_value, result.class_code,
						result.is_connected, result.has_fault);
				end
			end else begin
				want = normalized_q.pop_front();
				if (result.scaled_value !== want.scaled_value ||
						result.class_code !== want.class_code ||
						result.is_connected !== want.is_connected ||
						result.has_fault !== want.has_fault) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("%0t mismatch:", $time,
							" expected value=%0d class=%0d conn=%0b fault=%0b,",
							want.scaled_value, want.class_code, want.is_connected,
							want.has_fault,
							" actual value=%0d class=%0d conn=%0b fault=%0b",
							result.scaled_value, result.class_code,
							result.is_connected, result.has_fault);
					end
				end
			end
		end
		if (item_taken) begin
			normalized_q.push_back(normalize_record(item));
			taken_count++;
		end
		if (item_taken || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
	end

	initial begin
		int total_records;
		bit timed_out;
		timed_out = 1'b0;

		add_record(32'd0, 8'sd0, KIND_VOLT, UNIT_V, HEALTH_OK);
		add_record(32'hFFFF_FFFF, 8'sd127, KIND_VOLT, UNIT_V, 32'd0);
		add_record(32'hFFFF_FFFF, -8'sd128, KIND_CURR, UNIT_A, 32'hFFFF_FFFF);
		add_record(32'd5, -8'sd4, KIND_VOLT, UNIT_V, HEALTH_DEGRADED);
		add_record(32'd14, -8'sd4, KIND_CURR, UNIT_A, HEALTH_STRESSED);
		add_record(32'hFFFF_FFFF, -8'sd13, KIND_VOLT, UNIT_V, HEALTH_PRED_FAIL);
		add_record(32'd1234, -8'sd1, KIND_FAN, UNIT_RPM, HEALTH_ERROR);
		add_record(32'd7, 8'sd3, KIND_FAN, UNIT_RPM, HEALTH_NONRECOVER);
		add_record(32'd32000, -8'sd3, KIND_TEMP, UNIT_F, HEALTH_NO_CONTACT);
		add_record(32'd0, -8'sd3, KIND_TEMP, UNIT_F, HEALTH_LOST_COMM);
		add_record(32'hFFFF_FFFF, 8'sd6, KIND_TEMP, UNIT_F, HEALTH_ABORTED);
		add_record(32'hFFFF_FFFF, 8'sd127, KIND_TEMP, UNIT_F, HEALTH_SUPPORT_ERR);
		add_record(32'd0, 8'sd0, KIND_TEMP, UNIT_K, HEALTH_DONE_DEGRADED);
		add_record(32'd273150, -8'sd3, KIND_TEMP, UNIT_K, HEALTH_DONE_ERROR);
		add_record(32'd2500, -8'sd2, KIND_TEMP, UNIT_C, HEALTH_COMPLETED);
		add_record(32'd100, 8'sd0, KIND_TEMP, UNIT_V, HEALTH_OK);
		add_record(32'd100, 8'sd0, KIND_VOLT, UNIT_F, HEALTH_OK);
		add_record(32'd100, 8'sd0, 4'hF, 7'h7F, 32'd1);
		add_record(32'd1, -8'sd128, KIND_FAN, UNIT_RPM, HEALTH_STARTING);
		add_record(32'hFFFF_FFFF, 8'sd12, KIND_FAN, UNIT_RPM, HEALTH_STOPPING);
		add_record(32'hFFFF_FFFF, 8'sd7, KIND_VOLT, UNIT_V, HEALTH_IN_SERVICE);
		add_record(32'd15, -8'sd1, KIND_TEMP, UNIT_F, HEALTH_OK);
		add_record(32'd1, 8'sd0, KIND_TEMP, UNIT_K, HEALTH_OK);
		for (int i = 0; i < RANDOM_RECORDS; i++) begin
			record_q.push_back(random_record());
		end
		total_records = record_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (taken_count < total_records || normalized_q.size() != 0)) begin
			@(negedge clk);
			if (stall_cycles >= STALL_LIMIT) begin
				timed_out = 1'b1;
			end
		end
		if (timed_out) begin
			$display("CHECK FAILED");
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			if (errors == 0 && normalized_q.size() == 0) begin
				$display("CHECK OK");
			end else begin
				$display("CHECK FAILED");
			end
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/srn_pkg.sv
sv/srn_datapath.sv
sv/srn_status.sv
sv/srn_ctrl.sv
sv/sensor_reading_normalizer_unit.sv
sv/srn_checker.sv
test/tb_sensor_reading_normalizer_unit.sv
